// ===== rtl/sidechain_envelope_detector_assert.svh =====
// Assertion macros for the sidechain envelope detector.
// Included by the top level; no other dependencies.
`ifndef SIDECHAIN_ENVELOPE_DETECTOR_ASSERT_SVH
`define SIDECHAIN_ENVELOPE_DETECTOR_ASSERT_SVH

// same-cycle implication
`define SED_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// next-cycle implication
`define SED_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ===== rtl/sed_pkg.sv =====
// Shared types and constants for the sidechain envelope detector.
// No dependencies.
package sed_pkg;

   localparam int SAMPLE_BITS        = 24;
   localparam int MAX_WINDOW_DEFAULT = 4096;
   localparam int GAIN_W             = 16;
   localparam int GAIN_FRAC          = 12;
   localparam int LEN_W              = 13;
   localparam int RCP_W              = 25;
   localparam int RCP_FRAC           = 24;
   localparam int COEFF_W            = 16;
   localparam int LP_FRAC            = 16;
   localparam int CSR_INDEX_W        = 3;
   localparam int CSR_DATA_W         = 25;

   localparam logic [1:0] CH_MONO   = 2'd1;
   localparam logic [1:0] CH_STEREO = 2'd2;

   localparam logic [2:0] SRC_LEFT    = 3'd0;
   localparam logic [2:0] SRC_RIGHT   = 3'd1;
   localparam logic [2:0] SRC_MID     = 3'd2;
   localparam logic [2:0] SRC_SIDE    = 3'd3;
   localparam logic [2:0] SRC_SMALLER = 3'd4;
   localparam logic [2:0] SRC_LARGER  = 3'd5;

   localparam logic [1:0] MODE_PEAK    = 2'd0;
   localparam logic [1:0] MODE_RMS     = 2'd1;
   localparam logic [1:0] MODE_LOWPASS = 2'd2;
   localparam logic [1:0] MODE_MEAN    = 2'd3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHANNEL_COUNT     = 3'd0,
      CSR_MIDSIDE_LAYOUT    = 3'd1,
      CSR_SOURCE_SELECT     = 3'd2,
      CSR_DETECT_MODE       = 3'd3,
      CSR_PRE_GAIN          = 3'd4,
      CSR_WINDOW_LENGTH     = 3'd5,
      CSR_WINDOW_RECIPROCAL = 3'd6,
      CSR_LOWPASS_COEFF     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         channel_count;
      logic               midside_layout;
      logic [2:0]         source_select;
      logic [1:0]         detect_mode;
      logic [GAIN_W-1:0]  pre_gain;
      logic [LEN_W-1:0]   window_length;
      logic [RCP_W-1:0]   window_reciprocal;
      logic [COEFF_W-1:0] lowpass_coeff;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      channel_count:     CH_STEREO,
      midside_layout:    1'b0,
      source_select:     SRC_MID,
      detect_mode:       MODE_RMS,
      pre_gain:          16'd4096,
      window_length:     13'd1,
      window_reciprocal: 25'd16777216,
      lowpass_coeff:     16'd19195
   };

   typedef struct packed {
      logic load_mag;
      logic load_gain;
   } front_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GAIN,
      ST_WRITE,
      ST_SUM,
      ST_SQ_OLD,
      ST_SQ_NEW,
      ST_SQ_ADD,
      ST_SCALE_LO,
      ST_SCALE_HI,
      ST_SCALE_SUM,
      ST_FINISH,
      ST_ROOT,
      ST_LP_MUL,
      ST_LP_UPD,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/sidechain_envelope_detector.sv =====
// Sidechain envelope detector, top level: sequencer, history memory, sums.
// Depends on sed_pkg, sed_ram, sed_front, sed_isqrt and the assertion header.
//
// Input transactions (req_*) carry one sample pair and a clear flag; each gives
// exactly one result transaction (rsp_level). One item is in work at a time:
// req_stall is low only while the sequencer is idle. Windowed RMS ends in the
// bit-serial square root unless the scaled value saturates; an invalid channel
// count goes straight to a zero result. The next item can be taken in the cycle
// after the result is loaded.
// The history line sits in one RAM (read in the GAIN state, written in the WRITE
// state that follows); entries not yet written since the last clear read as zero
// by way of the write slot and a wrap flag, so no clearing pass is needed.
// Reset (synchronous) restores the register defaults and empties the state;
// any csr write or an accepted request with req_clear_first set does the same to the state.
// The result sits in an output register; while rsp_stall holds it, the next
// item is still accepted and worked, then waits for the register to free.
`include "sidechain_envelope_detector_assert.svh"

module sidechain_envelope_detector #(
   parameter int MAX_WINDOW = sed_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [sed_pkg::SAMPLE_BITS-1:0] req_in_a,
   input  logic signed [sed_pkg::SAMPLE_BITS-1:0] req_in_b,
   input  logic                                   req_clear_first,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [sed_pkg::SAMPLE_BITS-1:0]        rsp_level,
   input  logic                                   csr_write_en,
   input  logic [sed_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [sed_pkg::CSR_DATA_W-1:0]         csr_data
);
   import sed_pkg::*;

   localparam int AW     = $clog2(MAX_WINDOW);
   localparam int LW     = $clog2(MAX_WINDOW + 1);
   localparam int CW     = (LEN_W > LW) ? LEN_W : LW;
   localparam int SQ_W   = 2 * SAMPLE_BITS;
   localparam int SUM_W  = SQ_W + AW;
   localparam int LO_W   = (SUM_W + 1) / 2;
   localparam int MUL_W  = LO_W + RCP_W;
   localparam int PROD_W = SUM_W + RCP_W;
   localparam int SC_W   = PROD_W - RCP_FRAC;
   localparam int ACC_W  = SAMPLE_BITS + LP_FRAC;
   localparam int LPP_W  = ACC_W + COEFF_W;

   state_type state_ff, state_in;
   cfg_type   cfg_ff, cfg_in;

   logic [AW-1:0]    ws_ff, ws_in;
   logic             wrapped_ff, wrapped_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_level_ff;

   front_ctl_type    front_ctl;
   logic             accept, chan_bad, clear;
   logic             mem_rd_en, mem_wr_en, out_load, root_start, root_done;
   logic [SAMPLE_BITS-1:0] g_value, rd_data, root_value;

   logic [CW-1:0]    len_raw, len_clamped;
   logic [LW:0]      ws_x, len_x, rd_x;
   logic             old_ok;
   logic [AW-1:0]    rd_addr;
   logic             ws_last;

   logic             old_ok_ff;
   logic [SAMPLE_BITS-1:0] old_ff, level_ff, sq_op;
   logic [SQ_W-1:0]  sq_ff;
   logic [LO_W-1:0]  sc_op;
   logic [MUL_W-1:0] mul_ff, plo_ff;
   logic [PROD_W-1:0] sc_full;
   logic [SC_W-1:0]  scaled_ff;
   logic             rms_sat, mean_sat;

   logic [ACC_W:0]   lp_diff, lp_diff_neg;
   logic [ACC_W-1:0] lp_mag, lp_inc, lp_dec, lp_acc_next;
   logic [LPP_W:0]   lp_round;
   logic [LPP_W-1:0] lp_prod_ff;
   logic             lp_neg_ff;

   logic             state_empty;

   // ---------------------------------------------------------------- units
   sed_front u_front (
      .clock      (clock),
      .ctl        (front_ctl),
      .cfg        (cfg_ff),
      .in_a       (req_in_a),
      .in_b       (req_in_b),
      .gain_value (g_value)
   );

   sed_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_history (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (ws_ff),
      .wr_data (g_value),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sed_isqrt #(
      .ROOT_W (SAMPLE_BITS)
   ) u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (root_start),
      .operand (scaled_ff[SQ_W-1:0]),
      .done    (root_done),
      .root    (root_value)
   );

   // ---------------------------------------------------------------- address
   assign len_raw = CW'(cfg_ff.window_length);

   always_comb begin
      if (len_raw == '0) begin
         len_clamped = CW'(1);
      end else if (len_raw > CW'(MAX_WINDOW)) begin
         len_clamped = CW'(MAX_WINDOW);
      end else begin
         len_clamped = len_raw;
      end
   end

   assign ws_x    = (LW + 1)'(ws_ff);
   assign len_x   = {1'b0, len_clamped[LW-1:0]};
   assign old_ok  = wrapped_ff || (ws_x >= len_x);
   assign rd_x    = (ws_x >= len_x) ? (ws_x - len_x)
                  : (ws_x + (LW + 1)'(MAX_WINDOW) - len_x);
   assign rd_addr = rd_x[AW-1:0];
   assign ws_last = (ws_ff == AW'(MAX_WINDOW - 1));

   // ---------------------------------------------------------------- arithmetic
   assign sq_op = (state_ff == ST_SQ_OLD) ? old_ff : g_value;
   assign sc_op = (state_ff == ST_SCALE_LO) ? sum_ff[LO_W-1:0]
                : LO_W'(sum_ff[SUM_W-1:LO_W]);
   assign sc_full = (PROD_W'(mul_ff) << LO_W) + PROD_W'(plo_ff);

   assign rms_sat  = |scaled_ff[SC_W-1:SQ_W];
   assign mean_sat = |scaled_ff[SC_W-1:SAMPLE_BITS];

   assign lp_diff     = {1'b0, g_value, {LP_FRAC{1'b0}}} - {1'b0, acc_ff};
   assign lp_diff_neg = ~lp_diff + 1'b1;
   assign lp_mag      = lp_diff[ACC_W] ? lp_diff_neg[ACC_W-1:0] : lp_diff[ACC_W-1:0];
   assign lp_round    = {1'b0, lp_prod_ff} + (LPP_W + 1)'({LP_FRAC{1'b1}});
   assign lp_inc      = ACC_W'(lp_prod_ff >> LP_FRAC);
   assign lp_dec      = ACC_W'(lp_round >> LP_FRAC);
   assign lp_acc_next = lp_neg_ff ? (acc_ff - lp_dec) : (acc_ff + lp_inc);

   // ---------------------------------------------------------------- sequencer
   assign accept   = req_valid && !req_stall;
   assign chan_bad = (cfg_ff.channel_count != CH_MONO)
                  && (cfg_ff.channel_count != CH_STEREO);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = chan_bad ? ST_DONE : ST_GAIN;
            end
         end
         ST_GAIN:  state_in = ST_WRITE;
         ST_WRITE: begin
            case (cfg_ff.detect_mode)
               MODE_PEAK:    state_in = ST_DONE;
               MODE_RMS:     state_in = ST_SQ_OLD;
               MODE_LOWPASS: state_in = ST_LP_MUL;
               MODE_MEAN:    state_in = ST_SUM;
            endcase
         end
         ST_SUM:       state_in = ST_SCALE_LO;
         ST_SQ_OLD:    state_in = ST_SQ_NEW;
         ST_SQ_NEW:    state_in = ST_SQ_ADD;
         ST_SQ_ADD:    state_in = ST_SCALE_LO;
         ST_SCALE_LO:  state_in = ST_SCALE_HI;
         ST_SCALE_HI:  state_in = ST_SCALE_SUM;
         ST_SCALE_SUM: state_in = ST_FINISH;
         ST_FINISH: begin
            if ((cfg_ff.detect_mode == MODE_RMS) && !rms_sat) begin
               state_in = ST_ROOT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               state_in = ST_DONE;
            end
         end
         ST_LP_MUL: state_in = ST_LP_UPD;
         ST_LP_UPD: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      req_stall           = (state_ff != ST_IDLE);
      front_ctl.load_mag  = (state_ff == ST_IDLE) && req_valid;
      front_ctl.load_gain = (state_ff == ST_GAIN);
      mem_rd_en           = (state_ff == ST_GAIN);
      mem_wr_en           = (state_ff == ST_WRITE);
      root_start          = (state_ff == ST_FINISH) && (cfg_ff.detect_mode == MODE_RMS)
                         && !rms_sat;
      out_load            = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   // ---------------------------------------------------------------- state update
   always_comb begin
      cfg_in     = cfg_ff;
      clear      = 1'b0;
      ws_in      = ws_ff;
      wrapped_in = wrapped_ff;
      sum_in     = sum_ff;
      acc_in     = acc_ff;
      if (csr_write_en) begin
         clear = 1'b1;
         unique case (csr_index_type'(csr_index))
            CSR_CHANNEL_COUNT:     cfg_in.channel_count     = csr_data[1:0];
            CSR_MIDSIDE_LAYOUT:    cfg_in.midside_layout    = csr_data[0];
            CSR_SOURCE_SELECT:     cfg_in.source_select     = csr_data[2:0];
            CSR_DETECT_MODE:       cfg_in.detect_mode       = csr_data[1:0];
            CSR_PRE_GAIN:          cfg_in.pre_gain          = csr_data[GAIN_W-1:0];
            CSR_WINDOW_LENGTH:     cfg_in.window_length     = csr_data[LEN_W-1:0];
            CSR_WINDOW_RECIPROCAL: cfg_in.window_reciprocal = csr_data[RCP_W-1:0];
            CSR_LOWPASS_COEFF:     cfg_in.lowpass_coeff     = csr_data[COEFF_W-1:0];
         endcase
      end
      if (accept && req_clear_first) begin
         clear = 1'b1;
      end
      if (clear) begin
         ws_in      = '0;
         wrapped_in = 1'b0;
         sum_in     = '0;
         acc_in     = '0;
      end else begin
         case (state_ff)
            ST_WRITE: begin
               ws_in = ws_last ? '0 : ws_ff + 1'b1;
               if (ws_last) begin
                  wrapped_in = 1'b1;
               end
            end
            ST_SUM:    sum_in = sum_ff + SUM_W'(g_value) - SUM_W'(old_ff);
            ST_SQ_NEW: sum_in = sum_ff - SUM_W'(sq_ff);
            ST_SQ_ADD: sum_in = sum_ff + SUM_W'(sq_ff);
            ST_LP_UPD: acc_in = lp_acc_next;
            default: ;
         endcase
      end
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ff       <= CFG_RESET;
         ws_ff        <= '0;
         wrapped_ff   <= 1'b0;
         sum_ff       <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         ws_ff        <= ws_in;
         wrapped_ff   <= wrapped_in;
         sum_ff       <= sum_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && chan_bad) begin
               level_ff <= '0;
            end
         end
         ST_GAIN:  old_ok_ff <= old_ok;
         ST_WRITE: begin
            old_ff <= old_ok_ff ? rd_data : '0;
            if (cfg_ff.detect_mode == MODE_PEAK) begin
               level_ff <= g_value;
            end
         end
         ST_SQ_OLD, ST_SQ_NEW: sq_ff <= SQ_W'(sq_op) * SQ_W'(sq_op);
         ST_SCALE_LO: mul_ff <= MUL_W'(sc_op) * MUL_W'(cfg_ff.window_reciprocal);
         ST_SCALE_HI: begin
            plo_ff <= mul_ff;
            mul_ff <= MUL_W'(sc_op) * MUL_W'(cfg_ff.window_reciprocal);
         end
         ST_SCALE_SUM: scaled_ff <= sc_full[PROD_W-1:RCP_FRAC];
         ST_FINISH: begin
            if (cfg_ff.detect_mode == MODE_MEAN) begin
               level_ff <= mean_sat ? '1 : scaled_ff[SAMPLE_BITS-1:0];
            end else if (rms_sat) begin
               level_ff <= '1;
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               level_ff <= root_value;
            end
         end
         ST_LP_MUL: begin
            lp_prod_ff <= LPP_W'(lp_mag) * LPP_W'(cfg_ff.lowpass_coeff);
            lp_neg_ff  <= lp_diff[ACC_W];
         end
         ST_LP_UPD: level_ff <= lp_acc_next[ACC_W-1:LP_FRAC];
         default: ;
      endcase
      if (out_load) begin
         rsp_level_ff <= level_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = rsp_level_ff;

   // ---------------------------------------------------------------- checks
   assign state_empty = (ws_ff == '0) && !wrapped_ff && (sum_ff == '0) && (acc_ff == '0);

   `SED_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, req_stall)
   `SED_ASSERT_NEXT(a_clear_empties_state, clock, reset, accept && req_clear_first, state_empty)
   `SED_ASSERT_IMPLY(a_root_operand_fits, clock, reset, root_start, scaled_ff[SC_W-1:SQ_W] == '0)

endmodule

// ===== rtl/sed_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sed_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sed_front.sv =====
// Detector front end: source selection, magnitude, Q4.12 gain with saturation.
// Depends on sed_pkg.
module sed_front (
   input  logic                                 clock,
   input  sed_pkg::front_ctl_type               ctl,
   input  sed_pkg::cfg_type                     cfg,
   input  logic signed [sed_pkg::SAMPLE_BITS-1:0] in_a,
   input  logic signed [sed_pkg::SAMPLE_BITS-1:0] in_b,
   output logic [sed_pkg::SAMPLE_BITS-1:0]      gain_value
);
   import sed_pkg::*;

   localparam int MW = SAMPLE_BITS + 1;
   localparam int PW = MW + GAIN_W;

   logic signed [MW-1:0] a_x, b_x, sum_s, dif_s;
   logic [MW-1:0]        mag_a, mag_b, mag_sum, mag_dif, mag_sel;
   logic [MW-1:0]        mag_ff;
   logic [PW-1:0]        gain_prod;
   logic [SAMPLE_BITS-1:0] gain_sat;
   logic [SAMPLE_BITS-1:0] gain_ff;

   assign a_x   = {in_a[SAMPLE_BITS-1], in_a};
   assign b_x   = {in_b[SAMPLE_BITS-1], in_b};
   assign sum_s = a_x + b_x;
   assign dif_s = a_x - b_x;

   // two's complement negate; the full-scale sum reads back as 2^SAMPLE_BITS
   assign mag_a   = a_x[MW-1]   ? (~a_x + 1'b1)   : a_x;
   assign mag_b   = b_x[MW-1]   ? (~b_x + 1'b1)   : b_x;
   assign mag_sum = sum_s[MW-1] ? (~sum_s + 1'b1) : sum_s;
   assign mag_dif = dif_s[MW-1] ? (~dif_s + 1'b1) : dif_s;

   always_comb begin
      if (cfg.channel_count == CH_MONO) begin
         mag_sel = mag_a;
      end else if (cfg.midside_layout) begin
         case (cfg.source_select)
            SRC_LEFT:    mag_sel = mag_sum;
            SRC_RIGHT:   mag_sel = mag_dif;
            SRC_SIDE:    mag_sel = mag_b;
            SRC_SMALLER: mag_sel = (mag_sum < mag_dif) ? mag_sum : mag_dif;
            SRC_LARGER:  mag_sel = (mag_sum > mag_dif) ? mag_sum : mag_dif;
            default:     mag_sel = mag_a;
         endcase
      end else begin
         case (cfg.source_select)
            SRC_LEFT:    mag_sel = mag_a;
            SRC_RIGHT:   mag_sel = mag_b;
            SRC_SIDE:    mag_sel = mag_dif >> 1;
            SRC_SMALLER: mag_sel = (mag_a < mag_b) ? mag_a : mag_b;
            SRC_LARGER:  mag_sel = (mag_a > mag_b) ? mag_a : mag_b;
            default:     mag_sel = mag_sum >> 1;
         endcase
      end
   end

   assign gain_prod = PW'(mag_ff) * PW'(cfg.pre_gain);
   assign gain_sat  = (|gain_prod[PW-1:GAIN_FRAC+SAMPLE_BITS]) ? '1
                    : gain_prod[GAIN_FRAC+SAMPLE_BITS-1:GAIN_FRAC];

   always_ff @(posedge clock) begin
      if (ctl.load_mag) begin
         mag_ff <= mag_sel;
      end
      if (ctl.load_gain) begin
         gain_ff <= gain_sat;
      end
   end

   assign gain_value = gain_ff;

endmodule

// ===== rtl/sed_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Depends on sed_pkg for the default width.
module sed_isqrt #(
   parameter int ROOT_W = sed_pkg::SAMPLE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2*ROOT_W-1:0]   operand,
   output logic                  done,
   output logic [ROOT_W-1:0]     root
);
   import sed_pkg::*;

   localparam int CNT_W = $clog2(ROOT_W);

   logic [2*ROOT_W-1:0] rad_ff;
   logic [ROOT_W+1:0]   rem_ff;
   logic [ROOT_W-1:0]   root_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                busy_ff, done_ff;
   logic [ROOT_W+3:0]   rem_x, trial, rem_sub;
   logic                take;

   assign rem_x   = {rem_ff, rad_ff[2*ROOT_W-1 -: 2]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign take    = (rem_x >= trial);
   assign rem_sub = rem_x - trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(ROOT_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= operand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= take ? rem_sub[ROOT_W+1:0] : rem_x[ROOT_W+1:0];
         root_ff <= {root_ff[ROOT_W-2:0], take};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
